>>> sv/key_vector_debounce_fifo_defines.svh
// ----------------------------------------------------------------------------
// Key vector debounce FIFO assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef KEY_VECTOR_DEBOUNCE_FIFO_DEFINES_SVH
`define KEY_VECTOR_DEBOUNCE_FIFO_DEFINES_SVH
`ifndef SYNTHESIS
`define KVDF_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("kvdf: same-cycle check failed");
`define KVDF_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("kvdf: next-cycle check failed");
`else
`define KVDF_ASSERT_NOW(label, pre, post)
`define KVDF_ASSERT_NEXT(label, pre, post)
`endif
`endif

>>> sv/kvdf_pkg.sv
// ----------------------------------------------------------------------------
// Key vector debounce FIFO package
// Widths, codes, reset values and payload types shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kvdf_pkg;

    localparam int CODE_W    = 7;
    localparam int FUNC_W    = 2;
    localparam int COUNT_W   = 8;
    localparam int CFG_IDX_W = 1;

    // Keys taken into the pressed vector; bits above this count stay zero.
    localparam int NUM_KEYS = 7;
    localparam int DEF_QUEUE_DEPTH = 16;

    localparam logic [CODE_W-1:0] KEY_MASK = (NUM_KEYS >= CODE_W) ?
        {CODE_W{1'b1}} : CODE_W'((1 << NUM_KEYS) - 1);

    localparam logic [FUNC_W-1:0] FUNC_SCAN  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVELS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_TIME   = 1'd1;

    localparam logic [CODE_W-1:0] RST_ACTIVE_LEVELS = 7'd123;
    localparam logic [CODE_W-1:0] RST_FILTER_TIME   = 7'd5;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CODE_W-1:0] pin_levels;
    } kvdf_cmd_t;

    typedef struct packed {
        logic [CODE_W-1:0] key_code;
        logic              pushed;
        logic              queue_empty;
    } kvdf_result_t;

endpackage

>>> sv/kvdf_cmd_if.sv
// ----------------------------------------------------------------------------
// Key vector debounce FIFO command channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kvdf_cmd_if
    import kvdf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [CODE_W-1:0] pin_levels;

    modport source (output valid, output func, output pin_levels, input ready);
    modport sink (input valid, input func, input pin_levels, output ready);
endinterface

>>> sv/kvdf_res_if.sv
// ----------------------------------------------------------------------------
// Key vector debounce FIFO result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kvdf_res_if
    import kvdf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] key_code;
    logic              pushed;
    logic              queue_empty;

    modport source (output valid, output key_code, output pushed, output queue_empty,
                    input ready);
    modport sink (input valid, input key_code, input pushed, input queue_empty,
                  output ready);
endinterface

>>> sv/key_vector_debounce_fifo.sv
// ----------------------------------------------------------------------------
// Key vector debounce FIFO
// Each item is taken into an input register, processed and held in a result
// register, so one item is accepted per clock while res.ready does not stall
// the result register, and each result is offered from that register. A scan
// tick debounces the pressed-key vector with a shared counter and pushes it
// into a ring of QUEUE_DEPTH codes that overwrites without a full check; a
// read pops or repeats the last code and answers zero on the first read after
// the code changes; a clear empties the ring. The ring is a RAM read ahead
// with the next read pointer, since its read data is registered. Configuration
// writes are taken in any cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "key_vector_debounce_fifo_defines.svh"

module key_vector_debounce_fifo
    import kvdf_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CODE_W-1:0]    cfg_data,
    kvdf_cmd_if.sink             cmd,
    kvdf_res_if.source           res
);

    logic         in_valid_reg, in_valid_next;
    kvdf_cmd_t    in_cmd_reg;
    logic         out_valid_reg, out_valid_next;
    kvdf_result_t out_res_reg;
    kvdf_result_t core_result;
    logic         go;
    logic         cmd_accept;

    // The held item advances when the result register is free or being emptied.
    assign go         = in_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready  = !in_valid_reg || go;
    assign cmd_accept = cmd.valid && cmd.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (cmd_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (go)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (go)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    kvdf_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .go        (go),
        .cmd       (in_cmd_reg),
        .result    (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            in_cmd_reg.func       <= cmd.func;
            in_cmd_reg.pin_levels <= cmd.pin_levels;
        end
        if (go)
        begin
            out_res_reg <= core_result;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.key_code    = out_res_reg.key_code;
    assign res.pushed      = out_res_reg.pushed;
    assign res.queue_empty = out_res_reg.queue_empty;

    `KVDF_ASSERT_NEXT(a_go_fills_result, go, out_valid_reg)
    `KVDF_ASSERT_NOW(a_empty_stage_ready, !in_valid_reg, cmd.ready)
    `KVDF_ASSERT_NEXT(a_stall_keeps_item, in_valid_reg && out_valid_reg && !res.ready, in_valid_reg)

endmodule

>>> sv/kvdf_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kvdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/kvdf_core.sv
// ----------------------------------------------------------------------------
// Key vector debounce FIFO core
// Config registers, debounce filter, code ring and read gating for one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "key_vector_debounce_fifo_defines.svh"

module kvdf_core
    import kvdf_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CODE_W-1:0]    cfg_data,
    input  logic                 go,
    input  kvdf_cmd_t            cmd,
    output kvdf_result_t         result
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    logic [CODE_W-1:0]  active_levels_reg, active_levels_next;
    logic [CODE_W-1:0]  filter_time_reg, filter_time_next;
    logic [CODE_W-1:0]  accepted_reg, accepted_next;
    logic [COUNT_W-1:0] filter_count_reg, filter_count_next;
    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [PTR_W-1:0]   rp_reg, rp_next;
    logic [CODE_W-1:0]  last_fetched_reg, last_fetched_next;
    logic [CODE_W-1:0]  prior_fetched_reg, prior_fetched_next;
    logic               bypass_reg, bypass_next;
    logic [CODE_W-1:0]  bypass_data_reg;

    logic [CODE_W-1:0]  pressed;
    logic [COUNT_W-1:0] threshold;
    logic [COUNT_W-1:0] limit;
    logic [CODE_W-1:0]  head;
    logic [CODE_W-1:0]  fetched;
    logic               ram_we;
    logic [CODE_W-1:0]  ram_rdata;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        active_levels_next = active_levels_reg;
        filter_time_next   = filter_time_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ACTIVE_LEVELS: active_levels_next = cfg_data;
                REG_FILTER_TIME:   filter_time_next   = cfg_data;
                default: ;
            endcase
        end
    end

    assign pressed   = ~(cmd.pin_levels ^ active_levels_reg) & KEY_MASK;
    assign threshold = {1'b0, filter_time_reg};
    assign limit     = {filter_time_reg, 1'b0};
    // A write that lands on the address being read this cycle is forwarded.
    assign head      = bypass_reg ? bypass_data_reg : ram_rdata;

    always_comb
    begin
        accepted_next      = accepted_reg;
        filter_count_next  = filter_count_reg;
        wp_next            = wp_reg;
        rp_next            = rp_reg;
        last_fetched_next  = last_fetched_reg;
        prior_fetched_next = prior_fetched_reg;
        fetched            = last_fetched_reg;
        ram_we             = 1'b0;
        result             = '0;
        if (go)
        begin
            unique case (cmd.func)
                FUNC_SCAN:
                begin
                    if (pressed != accepted_reg)
                    begin
                        priority if (filter_count_reg < threshold)
                        begin
                            filter_count_next = threshold;
                        end
                        else if (filter_count_reg < limit)
                        begin
                            filter_count_next = filter_count_reg + 1'b1;
                        end
                        else
                        begin
                            ram_we            = 1'b1;
                            wp_next           = ptr_inc(wp_reg);
                            filter_count_next = '0;
                            accepted_next     = pressed;
                            result.pushed     = 1'b1;
                        end
                    end
                end
                FUNC_READ:
                begin
                    if (rp_reg != wp_reg)
                    begin
                        fetched = head;
                        rp_next = ptr_inc(rp_reg);
                    end
                    last_fetched_next  = fetched;
                    prior_fetched_next = fetched;
                    // The first read after the code changes answers zero.
                    result.key_code = (prior_fetched_reg != fetched) ? '0 : fetched;
                end
                FUNC_CLEAR:
                begin
                    rp_next = wp_reg;
                end
                default: ;
            endcase
        end
        result.queue_empty = (rp_next == wp_next);
    end

    assign bypass_next = ram_we && (wp_reg == rp_next);

    kvdf_ram #(
        .WIDTH (CODE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_code_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (pressed),
        .raddr (rp_next),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_levels_reg <= RST_ACTIVE_LEVELS;
            filter_time_reg   <= RST_FILTER_TIME;
            accepted_reg      <= '0;
            filter_count_reg  <= '0;
            wp_reg            <= '0;
            rp_reg            <= '0;
            last_fetched_reg  <= '0;
            prior_fetched_reg <= '0;
            bypass_reg        <= 1'b0;
        end
        else
        begin
            active_levels_reg <= active_levels_next;
            filter_time_reg   <= filter_time_next;
            accepted_reg      <= accepted_next;
            filter_count_reg  <= filter_count_next;
            wp_reg            <= wp_next;
            rp_reg            <= rp_next;
            last_fetched_reg  <= last_fetched_next;
            prior_fetched_reg <= prior_fetched_next;
            bypass_reg        <= bypass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bypass_data_reg <= pressed;
    end

    `KVDF_ASSERT_NEXT(a_bypass_capture, ram_we && (wp_reg == rp_next), bypass_reg)
    `KVDF_ASSERT_NEXT(a_clear_empties, go && (cmd.func == FUNC_CLEAR), rp_reg == wp_reg)
    `KVDF_ASSERT_NEXT(a_push_rearms, go && result.pushed, (filter_count_reg == '0) && (accepted_reg == $past(pressed)))

endmodule
